// File: src/contiguous_page_allocator_core_assert.svh
// Assertion macros for the contiguous page allocator.
// Expects signals named clk and rst in the scope that uses them.
`ifndef CONTIGUOUS_PAGE_ALLOCATOR_CORE_ASSERT_SVH
`define CONTIGUOUS_PAGE_ALLOCATOR_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define CPA_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define CPA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/cpa_pkg.sv
// Package for the contiguous page allocator: widths, codes, descriptor bits and states.
// Has no dependencies.
package cpa_pkg;

  localparam int NUM_PAGES_DEF  = 1024;
  localparam int PAGE_BYTES_DEF = 4096;
  localparam int ADDR_W         = 56;
  localparam int COUNT_W        = 11;
  localparam int STATUS_W       = 3;

  localparam logic [COUNT_W-1:0] USABLE_PAGES_RST = 11'd1024;

  typedef enum logic [STATUS_W-1:0] {
    ST_ALLOCATED = 3'd0,
    ST_FREED     = 3'd1,
    ST_FAILED    = 3'd2,
    ST_IGNORED   = 3'd3,
    ST_RANGE     = 3'd4
  } status_t;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_t;

  typedef enum logic {
    REG_USABLE_PAGES = 1'b0,
    REG_BASE_ADDRESS = 1'b1
  } reg_idx_t;

  typedef logic [1:0] desc_t;

  localparam desc_t DESC_FREE = 2'b01;
  localparam desc_t DESC_LAST = 2'b10;
  localparam desc_t DESC_USED = 2'b00;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_MARK,
    S_ADDR,
    S_RANGE_CHK,
    S_IDX_CHK,
    S_WALK,
    S_RESP
  } state_t;

endpackage

// File: src/contiguous_page_allocator_core.sv
// First-fit contiguous page allocator with one descriptor memory.
// Depends on cpa_pkg and contiguous_page_allocator_core_assert.svh.
// Allocate: scans the usable pages for the first free run, marks its pages and then forms
//   the address; it fails when no run fits, and a zero page count fails without a scan.
// Free: checks the range, then walks the block. The page size must be a power of two, as
//   the page index is a shift of the offset from the base; the block does not enforce it.
// One word is in work at a time; the next is taken at the edge after its result is loaded,
//   even while that result waits on the output. Reset clears the store.
`include "contiguous_page_allocator_core_assert.svh"

module contiguous_page_allocator_core import cpa_pkg::*; #(
  parameter int NUM_PAGES  = NUM_PAGES_DEF,
  parameter int PAGE_BYTES = PAGE_BYTES_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                write_enable,
  input  logic                write_index,
  input  logic [ADDR_W-1:0]   write_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                cmd,
  input  logic [COUNT_W-1:0]  page_count,
  input  logic [ADDR_W-1:0]   free_address,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [STATUS_W-1:0] status,
  output logic [ADDR_W-1:0]   block_address
);

  localparam int IDX_W     = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
  localparam int CNT_W     = $clog2(NUM_PAGES + 1);
  localparam int LIM_W     = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
  localparam int PB_W      = $clog2(PAGE_BYTES + 1);
  localparam int PB_SHIFT  = $clog2(PAGE_BYTES);
  localparam int PROD_W    = IDX_W + PB_W;

  localparam logic [LIM_W-1:0]     NUM_PAGES_L  = LIM_W'(NUM_PAGES);
  localparam logic [IDX_W-1:0]     LAST_IDX     = IDX_W'(NUM_PAGES - 1);
  localparam logic [PB_W-1:0]      PAGE_BYTES_L = PB_W'(PAGE_BYTES);

  logic [COUNT_W-1:0] usable_pages;
  logic [ADDR_W-1:0]  base_address;
  logic [LIM_W-1:0]   limit;

  desc_t              page_desc [NUM_PAGES];
  desc_t              rdata;
  logic               mem_we;
  logic [IDX_W-1:0]   mem_waddr;
  desc_t              mem_wdata;
  logic [IDX_W-1:0]   mem_raddr;

  state_t                state, state_next;
  logic [IDX_W-1:0]      clr_idx, clr_idx_next;
  logic [COUNT_W-1:0]    req_count, req_count_next;
  logic [ADDR_W-1:0]     req_addr, req_addr_next;
  logic [LIM_W-1:0]      scan_addr, scan_addr_next;
  logic                  pend, pend_next;
  logic [IDX_W-1:0]      pend_idx, pend_idx_next;
  logic [COUNT_W-1:0]    run, run_next;
  logic [IDX_W-1:0]      start, start_next;
  logic [IDX_W-1:0]      wr_idx, wr_idx_next;
  logic [COUNT_W-1:0]    left, left_next;
  logic [PROD_W-1:0]     prod, prod_next;
  logic                  first, first_next;
  status_t               res_status, res_status_next;
  logic [ADDR_W-1:0]     res_addr, res_addr_next;
  logic                  out_valid_next;
  logic [STATUS_W-1:0]   status_next;
  logic [ADDR_W-1:0]     block_address_next;

  logic [COUNT_W-1:0]    run_inc;
  logic [ADDR_W-1:0]     page_idx;

  assign limit = (LIM_W'(usable_pages) < NUM_PAGES_L) ? LIM_W'(usable_pages) : NUM_PAGES_L;

  assign page_idx = req_addr >> PB_SHIFT;

  always_ff @(posedge clk) begin
    if (rst) begin
      usable_pages <= USABLE_PAGES_RST;
      base_address <= '0;
    end else if (write_enable) begin
      case (write_index)
        REG_USABLE_PAGES: usable_pages <= write_data[COUNT_W-1:0];
        REG_BASE_ADDRESS: base_address <= write_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      page_desc[mem_waddr] <= mem_wdata;
    end
    rdata <= page_desc[mem_raddr];
  end

  always_comb begin
    state_next         = state;
    clr_idx_next       = clr_idx;
    req_count_next     = req_count;
    req_addr_next      = req_addr;
    scan_addr_next     = scan_addr;
    pend_next          = 1'b0;
    pend_idx_next      = pend_idx;
    run_next           = run;
    start_next         = start;
    wr_idx_next        = wr_idx;
    left_next          = left;
    prod_next          = prod;
    first_next         = first;
    res_status_next    = res_status;
    res_addr_next      = res_addr;
    out_valid_next     = out_valid && out_stall;
    status_next        = status;
    block_address_next = block_address;
    mem_we             = 1'b0;
    mem_waddr          = wr_idx;
    mem_wdata          = DESC_FREE;
    mem_raddr          = '0;
    in_stall           = 1'b1;
    run_inc            = '0;

    case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_idx;
        mem_wdata = DESC_FREE;
        if (clr_idx == LAST_IDX) begin
          state_next = S_IDLE;
        end else begin
          clr_idx_next = clr_idx + 1'b1;
        end
      end

      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          req_count_next = page_count;
          req_addr_next  = free_address;
          if (cmd == CMD_FREE) begin
            state_next = S_RANGE_CHK;
          end else if (page_count == '0) begin
            res_status_next = ST_FAILED;
            res_addr_next   = '0;
            state_next      = S_RESP;
          end else begin
            scan_addr_next = '0;
            run_next       = '0;
            state_next     = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        if (pend) begin
          if ((rdata & DESC_FREE) != DESC_USED) begin
            run_inc = run + 1'b1;
            if (run == '0) begin
              start_next = pend_idx;
            end
          end else begin
            run_inc = '0;
          end
          run_next = run_inc;
        end
        if (pend && (run_inc == req_count)) begin
          wr_idx_next = (run == '0) ? pend_idx : start;
          left_next   = req_count;
          state_next  = S_MARK;
        end else if (scan_addr < limit) begin
          mem_raddr      = scan_addr[IDX_W-1:0];
          pend_next      = 1'b1;
          pend_idx_next  = scan_addr[IDX_W-1:0];
          scan_addr_next = scan_addr + 1'b1;
        end else if (!pend) begin
          res_status_next = ST_FAILED;
          res_addr_next   = '0;
          state_next      = S_RESP;
        end
      end

      S_MARK: begin
        mem_we    = 1'b1;
        mem_waddr = wr_idx;
        mem_wdata = (left == COUNT_W'(1)) ? DESC_LAST : DESC_USED;
        prod_next = PROD_W'(start) * PROD_W'(PAGE_BYTES_L);
        if (left == COUNT_W'(1)) begin
          state_next = S_ADDR;
        end else begin
          wr_idx_next = wr_idx + 1'b1;
          left_next   = left - 1'b1;
        end
      end

      S_ADDR: begin
        res_status_next = ST_ALLOCATED;
        res_addr_next   = base_address + ADDR_W'(prod);
        state_next      = S_RESP;
      end

      S_RANGE_CHK: begin
        if (req_addr < base_address) begin
          res_status_next = ST_RANGE;
          res_addr_next   = '0;
          state_next      = S_RESP;
        end else begin
          req_addr_next = req_addr - base_address;
          state_next    = S_IDX_CHK;
        end
      end

      S_IDX_CHK: begin
        if (page_idx >= ADDR_W'(limit)) begin
          res_status_next = ST_RANGE;
          res_addr_next   = '0;
          state_next      = S_RESP;
        end else begin
          mem_raddr   = page_idx[IDX_W-1:0];
          wr_idx_next = page_idx[IDX_W-1:0];
          first_next  = 1'b1;
          state_next  = S_WALK;
        end
      end

      S_WALK: begin
        if (first && ((rdata & DESC_FREE) != DESC_USED)) begin
          res_status_next = ST_IGNORED;
          res_addr_next   = '0;
          state_next      = S_RESP;
        end else begin
          mem_we     = 1'b1;
          mem_waddr  = wr_idx;
          first_next = 1'b0;
          if ((rdata & DESC_LAST) != DESC_USED) begin
            mem_wdata       = DESC_FREE;
            res_status_next = ST_FREED;
            res_addr_next   = '0;
            state_next      = S_RESP;
          end else begin
            mem_wdata = rdata | DESC_FREE;
            if (wr_idx == LAST_IDX) begin
              res_status_next = ST_FREED;
              res_addr_next   = '0;
              state_next      = S_RESP;
            end else begin
              wr_idx_next = wr_idx + 1'b1;
              mem_raddr   = wr_idx + 1'b1;
            end
          end
        end
      end

      S_RESP: begin
        if (!out_valid || !out_stall) begin
          out_valid_next     = 1'b1;
          status_next        = res_status;
          block_address_next = res_addr;
          state_next         = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_idx   <= '0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      clr_idx   <= clr_idx_next;
      pend      <= pend_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    req_count     <= req_count_next;
    req_addr      <= req_addr_next;
    scan_addr     <= scan_addr_next;
    pend_idx      <= pend_idx_next;
    run           <= run_next;
    start         <= start_next;
    wr_idx        <= wr_idx_next;
    left          <= left_next;
    prod          <= prod_next;
    first         <= first_next;
    res_status    <= res_status_next;
    res_addr      <= res_addr_next;
    status        <= status_next;
    block_address <= block_address_next;
  end

  `CPA_ASSERT(a_addr_zero, out_valid && (status != ST_ALLOCATED), block_address == '0,
              "block address is nonzero on a result that is not an allocation")
  `CPA_ASSERT(a_run_bound, state == S_SCAN, run <= req_count,
              "free run length exceeds the requested page count")
  `CPA_ASSERT(a_mark_range, state == S_MARK, LIM_W'(wr_idx) < limit,
              "allocation marks a page beyond the usable pages")
  `CPA_ASSERT_NEXT(a_resp_hold, (state == S_RESP) && out_valid && out_stall, state == S_RESP,
                   "pending result left before the output register was free")

endmodule

// File: verif/tb.sv
// Self-checking testbench for contiguous_page_allocator_core: allocate and free words are
// predicted against a page ledger and every result is compared in order.
// Depends on cpa_pkg and the core RTL only.
`timescale 1ns / 100ps

class page_ledger;
  cpa_pkg::desc_t pages [cpa_pkg::NUM_PAGES_DEF];
  logic [cpa_pkg::COUNT_W-1:0] usable_pages;
  logic [cpa_pkg::ADDR_W-1:0] base_address;
  cpa_pkg::status_t want_status [$];
  logic [cpa_pkg::ADDR_W-1:0] want_address [$];
  int errors;
  int replies;
  int hits [8];

  function new();
    foreach (pages[i]) pages[i] = cpa_pkg::DESC_FREE;
    usable_pages = cpa_pkg::USABLE_PAGES_RST;
    base_address = '0;
    errors = 0;
    replies = 0;
    foreach (hits[i]) hits[i] = 0;
  endfunction

  function void write_reg(cpa_pkg::reg_idx_t idx, logic [cpa_pkg::ADDR_W-1:0] data);
    case (idx)
      cpa_pkg::REG_USABLE_PAGES: usable_pages = data[cpa_pkg::COUNT_W-1:0];
      cpa_pkg::REG_BASE_ADDRESS: base_address = data;
      default: ;
    endcase
  endfunction

  function int unsigned page_limit();
    return (usable_pages < cpa_pkg::NUM_PAGES_DEF) ? 32'(usable_pages) : cpa_pkg::NUM_PAGES_DEF;
  endfunction

  // First fit over the usable pages; nothing changes when no run is found.
  function cpa_pkg::status_t take_run(int unsigned count, output int unsigned start,
                                      output logic [cpa_pkg::ADDR_W-1:0] addr);
    int unsigned run;
    int unsigned i;
    int unsigned limit;
    start = 0;
    addr = '0;
    run = 0;
    limit = page_limit();
    if (count == 0) return cpa_pkg::ST_FAILED;
    for (i = 0; i < limit; i++) begin
      if ((pages[i] & cpa_pkg::DESC_FREE) != '0) begin
        if (run == 0) start = i;
        run++;
      end else begin
        run = 0;
      end
      if (run == count) begin
        for (int unsigned j = start; j < start + count; j++) pages[j] = cpa_pkg::DESC_USED;
        pages[start + count - 1] = cpa_pkg::DESC_LAST;
        addr = base_address + cpa_pkg::ADDR_W'(longint'(start) * cpa_pkg::PAGE_BYTES_DEF);
        return cpa_pkg::ST_ALLOCATED;
      end
    end
    start = 0;
    return cpa_pkg::ST_FAILED;
  endfunction

  // The walk stops at the page marked last or at the end of the store.
  function cpa_pkg::status_t release_block(logic [cpa_pkg::ADDR_W-1:0] address);
    logic [cpa_pkg::ADDR_W-1:0] offset;
    longint unsigned idx;
    if (address < base_address) return cpa_pkg::ST_RANGE;
    offset = address - base_address;
    idx = 64'(offset / cpa_pkg::ADDR_W'(cpa_pkg::PAGE_BYTES_DEF));
    if (idx >= page_limit()) return cpa_pkg::ST_RANGE;
    if ((pages[idx] & cpa_pkg::DESC_FREE) != '0) return cpa_pkg::ST_IGNORED;
    while (idx < cpa_pkg::NUM_PAGES_DEF) begin
      if ((pages[idx] & cpa_pkg::DESC_LAST) != '0) begin
        pages[idx] = cpa_pkg::DESC_FREE;
        break;
      end
      pages[idx] = pages[idx] | cpa_pkg::DESC_FREE;
      idx++;
    end
    return cpa_pkg::ST_FREED;
  endfunction

  function cpa_pkg::status_t note_request(cpa_pkg::cmd_t op,
                                          logic [cpa_pkg::COUNT_W-1:0] count,
                                          logic [cpa_pkg::ADDR_W-1:0] address,
                                          output int unsigned start);
    cpa_pkg::status_t st;
    logic [cpa_pkg::ADDR_W-1:0] addr;
    start = 0;
    addr = '0;
    if (op == cpa_pkg::CMD_ALLOC) st = take_run(32'(count), start, addr);
    else st = release_block(address);
    want_status.push_back(st);
    want_address.push_back(addr);
    return st;
  endfunction

  function void check_reply(logic [cpa_pkg::STATUS_W-1:0] st,
                            logic [cpa_pkg::ADDR_W-1:0] addr);
    cpa_pkg::status_t exp_st;
    logic [cpa_pkg::ADDR_W-1:0] exp_addr;
    if (want_status.size() == 0) begin
      $error("unexpected result: status %0d, block_address 0x%014h", st, addr);
      errors++;
      return;
    end
    exp_st = want_status.pop_front();
    exp_addr = want_address.pop_front();
    replies++;
    hits[exp_st]++;
    if (st !== exp_st) begin
      $error("status mismatch: expected %0d, got %0d", exp_st, st);
      errors++;
    end
    if (addr !== exp_addr) begin
      $error("block_address mismatch: expected 0x%014h, got 0x%014h", exp_addr, addr);
      errors++;
    end
  endfunction

  function int pending();
    return want_status.size();
  endfunction
endclass

module tb;
  import cpa_pkg::*;

  localparam int LIMIT_CYCLES = 8_000_000;
  localparam int HOLD_CYCLES  = 3000;
  localparam int TAIL_CYCLES  = 2 * (NUM_PAGES_DEF + 64);

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                write_enable = 1'b0;
  logic                write_index = REG_USABLE_PAGES;
  logic [ADDR_W-1:0]   write_data = '0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic                cmd = CMD_ALLOC;
  logic [COUNT_W-1:0]  page_count = '0;
  logic [ADDR_W-1:0]   free_address = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [STATUS_W-1:0] status;
  logic [ADDR_W-1:0]   block_address;

  logic hold_long = 1'b0;
  int idle_pct = 0;
  int stall_pct = 0;
  int cycles = 0;
  int sent = 0;
  int settings = 1;
  int unsigned live_blocks [$];
  page_ledger ledger = new();

  contiguous_page_allocator_core dut (
    .clk(clk), .rst(rst),
    .write_enable(write_enable), .write_index(write_index), .write_data(write_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .cmd(cmd), .page_count(page_count), .free_address(free_address),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .block_address(block_address)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT_CYCLES) begin
      $display("tb: failure");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) ledger.check_reply(status, block_address);
    out_stall <= hold_long || ($urandom_range(99) < stall_pct);
  end

  task automatic offer_request(cmd_t op, logic [COUNT_W-1:0] count,
                               logic [ADDR_W-1:0] address);
    int unsigned start;
    status_t st;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd <= op;
    page_count <= count;
    free_address <= address;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    st = ledger.note_request(op, count, address, start);
    if (op == CMD_ALLOC && st == ST_ALLOCATED) live_blocks.push_back(start);
    sent++;
  endtask

  task automatic drain_replies();
    in_valid <= 1'b0;
    do @(posedge clk); while (ledger.pending() != 0);
  endtask

  task automatic program_registers(logic [COUNT_W-1:0] usable, logic [ADDR_W-1:0] base);
    write_enable <= 1'b1;
    write_index <= REG_USABLE_PAGES;
    write_data <= ADDR_W'(usable);
    @(posedge clk);
    ledger.write_reg(REG_USABLE_PAGES, ADDR_W'(usable));
    write_index <= REG_BASE_ADDRESS;
    write_data <= base;
    @(posedge clk);
    ledger.write_reg(REG_BASE_ADDRESS, base);
    write_enable <= 1'b0;
    settings++;
  endtask

  // Mostly allocations and frees of live blocks, with some noise mixed in.
  task automatic random_request();
    int unsigned lim;
    int unsigned roll;
    int unsigned k;
    int unsigned page;
    logic [ADDR_W-1:0] addr;
    logic [ADDR_W-1:0] junk;
    logic [COUNT_W-1:0] junk_count;
    lim = ledger.page_limit();
    roll = $urandom_range(99);
    junk = ADDR_W'({$urandom, $urandom});
    junk_count = COUNT_W'($urandom);
    if (roll < 15) begin
      case ($urandom_range(3))
        0: offer_request(CMD_FREE, junk_count, junk);
        1: begin
          page = $urandom_range(lim + 2);
          addr = ledger.base_address + ADDR_W'(longint'(page) * PAGE_BYTES_DEF)
                 + ADDR_W'($urandom_range(PAGE_BYTES_DEF - 1));
          offer_request(CMD_FREE, junk_count, addr);
        end
        2: offer_request(CMD_ALLOC, COUNT_W'($urandom_range(2047)), junk);
        default: offer_request(CMD_ALLOC, '0, junk);
      endcase
    end else if ((roll < 55 && live_blocks.size() > 0) || live_blocks.size() > 12) begin
      k = $urandom_range(live_blocks.size() - 1);
      page = live_blocks[k];
      live_blocks.delete(k);
      if ($urandom_range(7) == 0) page++;
      addr = ledger.base_address + ADDR_W'(longint'(page) * PAGE_BYTES_DEF);
      if ($urandom_range(3) == 0) addr = addr + ADDR_W'($urandom_range(1, PAGE_BYTES_DEF - 1));
      offer_request(CMD_FREE, junk_count, addr);
    end else begin
      if ($urandom_range(9) == 0 && lim > 0) k = $urandom_range(1, lim);
      else k = $urandom_range(1, 8);
      offer_request(CMD_ALLOC, COUNT_W'(k), junk);
    end
  endtask

  task automatic random_requests(int n);
    repeat (n) random_request();
  endtask

  initial begin
    logic [ADDR_W-1:0] rand_base;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    offer_request(CMD_ALLOC, 11'd0, '0);
    offer_request(CMD_ALLOC, 11'd2047, '0);
    offer_request(CMD_ALLOC, 11'd1, '0);
    offer_request(CMD_ALLOC, 11'd3, '0);
    offer_request(CMD_FREE, 11'd2047, 56'h1123);
    offer_request(CMD_FREE, 11'd0, 56'h1000);
    offer_request(CMD_FREE, 11'd5, {ADDR_W{1'b1}});
    offer_request(CMD_FREE, 11'd0, 56'h0);
    offer_request(CMD_ALLOC, 11'd1024, {ADDR_W{1'b1}});
    offer_request(CMD_ALLOC, 11'd1, '0);
    offer_request(CMD_FREE, 11'd0, 56'h1F_4FFF);
    offer_request(CMD_FREE, 11'd0, 56'h0);
    drain_replies();

    program_registers(11'd2047, 56'hFF_FFFF_FFF0_0000);
    offer_request(CMD_ALLOC, 11'd300, '0);
    offer_request(CMD_ALLOC, 11'd5, '0);
    offer_request(CMD_FREE, 11'd0, 56'h1000);
    offer_request(CMD_FREE, 11'd0, 56'h2_C000);
    offer_request(CMD_FREE, 11'd0, 56'hFF_FFFF_FFF0_0000);
    drain_replies();

    program_registers(11'd16, 56'h1_0000);
    offer_request(CMD_ALLOC, 11'd17, '0);
    offer_request(CMD_ALLOC, 11'd16, '0);
    offer_request(CMD_FREE, 11'd0, 56'h2_0000);
    offer_request(CMD_FREE, 11'd0, 56'h1_F000);
    offer_request(CMD_FREE, 11'd0, 56'h1_0000);
    drain_replies();

    program_registers(11'd0, '0);
    offer_request(CMD_ALLOC, 11'd1, '0);
    offer_request(CMD_FREE, 11'd0, '0);
    drain_replies();
    live_blocks.delete();

    program_registers(11'd64, 56'h00_0123_4560_0000);
    random_requests(120);
    drain_replies();

    program_registers(11'd1024, '0);
    idle_pct = 50;
    random_requests(60);
    drain_replies();
    random_requests(60);
    drain_replies();

    program_registers(11'd2047, 56'hFF_FFFF_FFFF_F000);
    idle_pct = 0;
    stall_pct = 50;
    fork
      begin
        hold_long <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_long <= 1'b0;
      end
    join_none
    random_requests(120);
    drain_replies();

    rand_base = ADDR_W'({$urandom, $urandom}) & ~ADDR_W'(PAGE_BYTES_DEF - 1);
    program_registers(11'd37, rand_base);
    idle_pct = 27;
    stall_pct = 27;
    random_requests(120);
    drain_replies();

    program_registers(11'd0, '0);
    random_requests(15);
    drain_replies();

    program_registers(11'd1, {ADDR_W{1'b1}});
    idle_pct = 0;
    stall_pct = 0;
    random_requests(60);
    drain_replies();

    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Covered %0d words over %0d register settings in %0d cycles, %0d results checked.",
             sent, settings, cycles, ledger.replies);
    $display("Results: %0d allocated, %0d freed, %0d failed, %0d already free, %0d out of range.",
             ledger.hits[ST_ALLOCATED], ledger.hits[ST_FREED], ledger.hits[ST_FAILED],
             ledger.hits[ST_IGNORED], ledger.hits[ST_RANGE]);
    if (ledger.errors == 0 && ledger.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
